// ===== rtl/core/sle_pkg.sv =====
// sle_pkg: shared types and constants for the sequential list engine
// no dependencies; imported by sle_ctrl, sle_dpath and the top level
`timescale 1ns / 1ps

package sle_pkg;

    localparam int CAPACITY_DEF = 128;

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_GET    = 3'd2,
        CMD_LOCATE = 3'd3,
        CMD_PRED   = 3'd4,
        CMD_SUCC   = 3'd5,
        CMD_CLEAR  = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2,
        ST_NONE    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        DP_HOLD  = 2'd0,
        DP_LATCH = 2'd1,
        DP_STEP  = 2'd2,
        DP_EMIT  = 2'd3
    } t_dp_op;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_RUN  = 1'b1
    } t_state;

    typedef struct packed {
        logic walk_done;
        logic out_full;
    } t_dp_stat;

endpackage

// ===== rtl/core/sle_ctrl.sv =====
// sle_ctrl: controller state machine, sequences latch, store walk and result emit
// depends on sle_pkg; drives sle_dpath through t_dp_op
`timescale 1ns / 1ps

module sle_ctrl import sle_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  logic     i_out_ready,
    output logic     o_out_valid,
    input  t_dp_stat i_stat,
    output t_dp_op   o_op
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_op    = DP_HOLD;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = DP_LATCH;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (!i_stat.walk_done) begin
                    o_op = DP_STEP;
                end else if (!i_stat.out_full || i_out_ready) begin
                    o_op    = DP_EMIT;
                    n_state = S_IDLE;
                end
            end
        endcase
        if (o_op == DP_EMIT) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/sle_dpath.sv =====
// sle_dpath: list store, element count, walk counters, compare and result registers
// depends on sle_pkg; commanded by sle_ctrl
`timescale 1ns / 1ps

module sle_dpath import sle_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_op             i_op,
    input  logic               i_out_valid,
    output t_dp_stat           o_stat,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic [2:0]         i_command,
    input  logic [7:0]         i_position,
    input  logic signed [31:0] i_value,
    output t_status            o_status,
    output logic signed [31:0] o_result_value,
    output logic [7:0]         o_found_position,
    output logic [7:0]         o_list_length
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = (CW > 8) ? CW + 1 : 9;

    logic [31:0] r_mem [CAPACITY];
    logic [31:0] r_rdata;

    logic          r_mode, n_mode;
    logic [CW-1:0] r_count, n_count;
    t_cmd          r_cmd, n_cmd;
    t_status       r_err, n_err;
    logic [CW-1:0] r_addr, n_addr;
    logic [CW-1:0] r_rem, n_rem;
    logic [CW-1:0] r_da, n_da;
    logic [CW-1:0] r_put, n_put;
    logic [CW-1:0] r_fpos, n_fpos;
    logic          r_pend, n_pend;
    logic          r_first, n_first;
    logic          r_hit, n_hit;
    logic [31:0]   r_val, n_val;
    logic [31:0]   r_target, n_target;
    logic [31:0]   r_prev, n_prev;
    logic [31:0]   r_res, n_res;
    t_status       r_o_status, n_o_status;
    logic [31:0]   r_o_result, n_o_result;
    logic [7:0]    r_o_found, n_o_found;
    logic [7:0]    r_o_len, n_o_len;

    logic          rd_en;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic [31:0]   sq;
    logic [EW-1:0] pe;
    logic [EW-1:0] ce;
    t_cmd          in_cmd;
    logic          is_scan;
    logic          match;
    t_status       st;
    logic [31:0]   res;
    logic [CW-1:0] fnd;

    assign sq      = 32'(i_value * i_value);
    assign pe      = EW'(i_position);
    assign ce      = EW'(r_count);
    assign in_cmd  = t_cmd'(i_command);
    assign is_scan = (r_cmd == CMD_LOCATE) || (r_cmd == CMD_PRED) || (r_cmd == CMD_SUCC);
    assign match   = r_pend && is_scan && (r_rdata == r_target);

    always_comb begin
        n_mode     = i_cfg_we ? i_cfg_wdata : r_mode;
        n_count    = r_count;
        n_cmd      = r_cmd;
        n_err      = r_err;
        n_addr     = r_addr;
        n_rem      = r_rem;
        n_da       = r_da;
        n_put      = r_put;
        n_fpos     = r_fpos;
        n_pend     = r_pend;
        n_first    = r_first;
        n_hit      = r_hit;
        n_val      = r_val;
        n_target   = r_target;
        n_prev     = r_prev;
        n_res      = r_res;
        n_o_status = r_o_status;
        n_o_result = r_o_result;
        n_o_found  = r_o_found;
        n_o_len    = r_o_len;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = r_da[AW-1:0];
        wr_data    = r_rdata;
        st         = r_err;
        res        = '0;
        fnd        = '0;
        unique case (i_op)
            DP_HOLD: begin
            end
            DP_LATCH: begin
                n_cmd    = in_cmd;
                n_val    = i_value;
                n_target = ((in_cmd == CMD_LOCATE) && r_mode) ? sq : i_value;
                n_put    = CW'(pe - EW'(1));
                n_pend   = 1'b0;
                n_hit    = 1'b0;
                n_first  = 1'b0;
                n_fpos   = '0;
                n_rem    = '0;
                n_addr   = '0;
                n_err    = ST_OK;
                unique case (in_cmd)
                    CMD_INSERT: begin
                        if (pe == '0 || pe > ce + EW'(1)) begin
                            n_err = ST_BAD_POS;
                        end else if (r_count == CW'(CAPACITY)) begin
                            n_err = ST_FULL;
                        end else begin
                            n_addr = r_count - CW'(1);
                            n_rem  = CW'(ce - pe + EW'(1));
                        end
                    end
                    CMD_DELETE, CMD_GET: begin
                        if (pe == '0 || pe > ce) begin
                            n_err = ST_BAD_POS;
                        end else begin
                            n_addr  = CW'(pe - EW'(1));
                            n_rem   = (in_cmd == CMD_DELETE) ? CW'(ce - pe + EW'(1)) : CW'(1);
                            n_first = 1'b1;
                        end
                    end
                    CMD_LOCATE, CMD_PRED, CMD_SUCC: begin
                        n_rem = r_count;
                    end
                    default: begin
                    end
                endcase
            end
            DP_STEP: begin
                if (r_rem != '0) begin
                    rd_en  = 1'b1;
                    n_da   = r_addr;
                    n_addr = (r_cmd == CMD_INSERT) ? r_addr - CW'(1) : r_addr + CW'(1);
                    n_rem  = r_rem - CW'(1);
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    unique case (r_cmd)
                        CMD_INSERT: begin
                            wr_en   = 1'b1;
                            wr_addr = AW'(r_da + CW'(1));
                        end
                        CMD_DELETE, CMD_GET: begin
                            if (r_first) begin
                                n_res   = r_rdata;
                                n_first = 1'b0;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = AW'(r_da - CW'(1));
                            end
                        end
                        CMD_LOCATE, CMD_PRED, CMD_SUCC: begin
                            if (match) begin
                                n_hit  = 1'b1;
                                n_fpos = r_da + CW'(1);
                                n_rem  = '0;
                                n_pend = 1'b0;
                            end else begin
                                n_prev = r_rdata;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            DP_EMIT: begin
                if (r_err == ST_OK) begin
                    unique case (r_cmd)
                        CMD_INSERT: begin
                            wr_en   = 1'b1;
                            wr_addr = r_put[AW-1:0];
                            wr_data = r_val;
                            n_count = r_count + CW'(1);
                        end
                        CMD_DELETE: begin
                            res     = r_res;
                            n_count = r_count - CW'(1);
                        end
                        CMD_GET: begin
                            res = r_res;
                        end
                        CMD_LOCATE: begin
                            if (r_hit) begin
                                fnd = r_fpos;
                            end else begin
                                st = ST_NONE;
                            end
                        end
                        CMD_PRED: begin
                            if (r_hit && r_fpos > CW'(1)) begin
                                res = r_prev;
                            end else begin
                                st = ST_NONE;
                            end
                        end
                        CMD_SUCC: begin
                            if (r_hit && r_fpos < r_count) begin
                                res = r_rdata;
                            end else begin
                                st = ST_NONE;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
                n_o_status = st;
                n_o_result = res;
                n_o_found  = 8'(fnd);
                n_o_len    = 8'(n_count);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_count <= '0;
            r_rem   <= '0;
            r_pend  <= 1'b0;
            r_first <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_count <= n_count;
            r_rem   <= n_rem;
            r_pend  <= n_pend;
            r_first <= n_first;
            r_hit   <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_err      <= n_err;
        r_addr     <= n_addr;
        r_da       <= n_da;
        r_put      <= n_put;
        r_fpos     <= n_fpos;
        r_val      <= n_val;
        r_target   <= n_target;
        r_prev     <= n_prev;
        r_res      <= n_res;
        r_o_status <= n_o_status;
        r_o_result <= n_o_result;
        r_o_found  <= n_o_found;
        r_o_len    <= n_o_len;
    end

    // simple dual-port store: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[r_addr[AW-1:0]];
        end
    end

    assign o_stat.walk_done = (r_rem == '0) && !r_pend;
    assign o_stat.out_full  = i_out_valid;
    assign o_status         = r_o_status;
    assign o_result_value   = $signed(r_o_result);
    assign o_found_position = r_o_found;
    assign o_list_length    = r_o_len;

endmodule

// ===== rtl/core/sequential_list_engine_core.sv =====
// after a command beat is taken the controller latches it, walks the list store and then loads
// the result beat; the walk does no reads for errors, clear, no-op and an append, one for get,
// up to count for insert, delete, locate, predecessor and successor (at most CAPACITY)
// one command at a time; emit waits while a result is untaken
// reset: synchronous active-low i_rst_n clears control, element count and match mode;
// store contents stay undefined, no clearing pass
`timescale 1ns / 1ps

module sequential_list_engine_core import sle_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_command,
    input  logic [7:0]         i_position,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_status            o_status,
    output logic signed [31:0] o_result_value,
    output logic [7:0]         o_found_position,
    output logic [7:0]         o_list_length
);

    t_dp_op   op;
    t_dp_stat stat;

    sle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_stat      (stat),
        .o_op        (op)
    );

    sle_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (op),
        .i_out_valid      (o_out_valid),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_command        (i_command),
        .i_position       (i_position),
        .i_value          (i_value),
        .o_status         (o_status),
        .o_result_value   (o_result_value),
        .o_found_position (o_found_position),
        .o_list_length    (o_list_length)
    );

`ifndef SYNTH
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("command beat taken while another is in flight");

    a_err_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_result_value == 32'sd0))
        else $error("error result carries a nonzero value");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found_position != 8'd0) |-> (o_status == ST_OK))
        else $error("found position reported with error status");

    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op == DP_EMIT) |-> (!o_out_valid || i_out_ready))
        else $error("result loaded over an untaken beat");
`endif

endmodule

// ===== dv/sequential_list_engine_core_test.sv =====
// self-checking testbench for sequential_list_engine_core: directed and random list commands
// predicts each reply from an internal list copy; depends on sle_pkg and the rtl top level
`timescale 1ns / 1ps

module sequential_list_engine_core_test;
    import sle_pkg::*;

    localparam int CAPACITY = CAPACITY_DEF;
    localparam logic [2:0] CMD_NOP = 3'd7;
    localparam int IDLE_PCT = 24;
    localparam logic [31:0] WORD_MIN = 32'h8000_0000;
    localparam logic [31:0] WORD_MAX = 32'h7fff_ffff;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  pos;
        logic [31:0] val;
    } list_cmd_t;

    typedef struct packed {
        t_status     status;
        logic [31:0] value;
        logic [7:0]  found;
        logic [7:0]  length;
    } list_reply_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_wdata = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [2:0]         i_command = '0;
    logic [7:0]         i_position = '0;
    logic signed [31:0] i_value = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_status            o_status;
    logic signed [31:0] o_result_value;
    logic [7:0]         o_found_position;
    logic [7:0]         o_list_length;

    sequential_list_engine_core #(.CAPACITY(CAPACITY)) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_position       (i_position),
        .i_value          (i_value),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_result_value   (o_result_value),
        .o_found_position (o_found_position),
        .o_list_length    (o_list_length)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [31:0] list_model [CAPACITY];
    int          list_count = 0;
    logic        match_sq = 1'b0;
    logic [31:0] value_pool [16];

    list_cmd_t   pending_cmds [$];
    list_reply_t predicted_replies [$];
    list_cmd_t   next_cmd;
    list_reply_t seen_reply;
    list_reply_t want_reply;
    logic        in_beat_taken = 1'b0;
    bit          quiet_run = 1'b0;

    int error_count = 0;
    int cmds_taken = 0;
    int replies_checked = 0;
    int peak_length = 0;
    int status_tally [4] = '{0, 0, 0, 0};

    function automatic int find_first(input logic [31:0] target);
        for (int i = 0; i < list_count; i++) begin
            if (list_model[i] === target) return i + 1;
        end
        return 0;
    endfunction

    task automatic apply_list_command(input logic [2:0] cmd, input logic [7:0] pos,
                                      input logic [31:0] val);
        list_reply_t r;
        logic [31:0] target;
        int at, p, i;
        at = pos;
        r.status = ST_OK;
        r.value = '0;
        r.found = '0;
        case (cmd)
            CMD_INSERT: begin
                if (at < 1 || at > list_count + 1) r.status = ST_BAD_POS;
                else if (list_count >= CAPACITY) r.status = ST_FULL;
                else begin
                    for (i = list_count; i >= at; i--) list_model[i] = list_model[i - 1];
                    list_model[at - 1] = val;
                    list_count++;
                end
            end
            CMD_DELETE: begin
                if (at < 1 || at > list_count) r.status = ST_BAD_POS;
                else begin
                    r.value = list_model[at - 1];
                    for (i = at; i < list_count; i++) list_model[i - 1] = list_model[i];
                    list_count--;
                end
            end
            CMD_GET: begin
                if (at < 1 || at > list_count) r.status = ST_BAD_POS;
                else r.value = list_model[at - 1];
            end
            CMD_LOCATE: begin
                target = match_sq ? val * val : val;
                p = find_first(target);
                if (p == 0) r.status = ST_NONE;
                else r.found = 8'(p);
            end
            CMD_PRED: begin
                p = find_first(val);
                if (p <= 1) r.status = ST_NONE;
                else r.value = list_model[p - 2];
            end
            CMD_SUCC: begin
                p = find_first(val);
                if (p == 0 || p >= list_count) r.status = ST_NONE;
                else r.value = list_model[p];
            end
            CMD_CLEAR: list_count = 0;
            default: ;
        endcase
        r.length = 8'(list_count);
        if (list_count > peak_length) peak_length = list_count;
        status_tally[r.status]++;
        predicted_replies.push_back(r);
    endtask

    // driver: new beat only when the line is free or the last one was taken
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_beat_taken)) begin
            if (pending_cmds.size() != 0 && (quiet_run || $urandom_range(99) >= IDLE_PCT)) begin
                next_cmd = pending_cmds.pop_front();
                i_command <= next_cmd.cmd;
                i_position <= next_cmd.pos;
                i_value <= next_cmd.val;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) i_out_ready <= quiet_run || ($urandom_range(99) >= IDLE_PCT);
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            in_beat_taken <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) begin
                apply_list_command(i_command, i_position, i_value);
                cmds_taken++;
            end
            if (o_out_valid && i_out_ready) begin
                seen_reply.status = o_status;
                seen_reply.value = o_result_value;
                seen_reply.found = o_found_position;
                seen_reply.length = o_list_length;
                if (predicted_replies.size() == 0) begin
                    $display("%0t: unexpected reply beat: status %0d value %h found %0d length %0d",
                             $time, seen_reply.status, seen_reply.value, seen_reply.found,
                             seen_reply.length);
                    error_count++;
                end else begin
                    want_reply = predicted_replies.pop_front();
                    replies_checked++;
                    if (seen_reply !== want_reply) begin
                        $display("%0t: reply mismatch: expected status %0d value %h found %0d length %0d, got status %0d value %h found %0d length %0d",
                                 $time, want_reply.status, want_reply.value, want_reply.found,
                                 want_reply.length, seen_reply.status, seen_reply.value,
                                 seen_reply.found, seen_reply.length);
                        error_count++;
                    end
                end
            end
        end
    end

    task automatic push_cmd(input logic [2:0] cmd, input logic [7:0] pos, input logic [31:0] val);
        list_cmd_t b;
        b.cmd = cmd;
        b.pos = pos;
        b.val = val;
        pending_cmds.push_back(b);
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || i_in_valid || predicted_replies.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        wait_drained();
        repeat (2) @(negedge i_clk);
        i_cfg_wdata <= m;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        match_sq = m;
    endtask

    function automatic logic [7:0] pick_pos(input int c, input bit for_insert);
        int top;
        top = for_insert ? c + 1 : c;
        case ($urandom_range(19))
            0: return 8'd0;
            1: return (top < 255) ? 8'($urandom_range(255, top + 1)) : 8'd255;
            2: return 8'(top);
            3: return 8'd1;
            default: return (top > 0) ? 8'($urandom_range(top, 1)) : 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [31:0] pick_word(input int c);
        logic [31:0] s;
        s = value_pool[$urandom_range(15)];
        case ($urandom_range(3))
            0: return s;
            1: return s * s;
            2: return (c > 0 && $urandom_range(1)) ? list_model[$urandom_range(c - 1)] : $urandom;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_key(input int c);
        int roll;
        roll = $urandom_range(9);
        if (roll < 6 && c > 0) return list_model[$urandom_range(c - 1)];
        if (roll < 8) return value_pool[$urandom_range(15)];
        return $urandom;
    endfunction

    task automatic run_random(input int total, input int ins_pct, input int del_pct,
                              input int clr_pct);
        list_cmd_t b;
        int k, c, roll;
        for (k = 0; k < total; k++) begin
            while (pending_cmds.size() > 2) @(negedge i_clk);
            c = list_count;
            roll = $urandom_range(99);
            b.val = pick_key(c);
            b.pos = pick_pos(c, 1'b0);
            if (roll < ins_pct) begin
                b.cmd = CMD_INSERT;
                b.val = pick_word(c);
                b.pos = pick_pos(c, 1'b1);
            end else if (roll < ins_pct + del_pct) begin
                b.cmd = CMD_DELETE;
            end else if (roll < ins_pct + del_pct + clr_pct) begin
                b.cmd = CMD_CLEAR;
            end else begin
                roll = $urandom_range(99);
                if (roll < 2) b.cmd = CMD_NOP;
                else if (roll < 20) b.cmd = CMD_GET;
                else if (roll < 50) b.cmd = CMD_LOCATE;
                else if (roll < 75) b.cmd = CMD_PRED;
                else b.cmd = CMD_SUCC;
            end
            pending_cmds.push_back(b);
        end
    endtask

    initial begin
        value_pool[0] = 32'd0;
        value_pool[1] = 32'd1;
        value_pool[2] = 32'hffff_ffff;
        value_pool[3] = WORD_MIN;
        value_pool[4] = WORD_MAX;
        value_pool[5] = 32'd3;
        value_pool[6] = 32'd46341;
        value_pool[7] = 32'd65536;
        for (int i = 8; i < 16; i++) value_pool[i] = $urandom;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_mode(1'b0);
        push_cmd(CMD_GET, 8'd1, 32'd0);
        push_cmd(CMD_DELETE, 8'd1, 32'd0);
        push_cmd(CMD_INSERT, 8'd0, 32'd5);
        push_cmd(CMD_INSERT, 8'd2, 32'd5);
        push_cmd(CMD_INSERT, 8'd1, WORD_MIN);
        push_cmd(CMD_INSERT, 8'd2, WORD_MAX);
        push_cmd(CMD_INSERT, 8'd1, 32'hffff_ffff);
        push_cmd(CMD_INSERT, 8'd4, 32'd0);
        push_cmd(CMD_GET, 8'd4, 32'd0);
        push_cmd(CMD_GET, 8'd5, 32'd0);
        push_cmd(CMD_LOCATE, 8'd0, WORD_MAX);
        push_cmd(CMD_LOCATE, 8'd0, 32'd5);
        push_cmd(CMD_PRED, 8'd0, 32'hffff_ffff);
        push_cmd(CMD_PRED, 8'd0, WORD_MIN);
        push_cmd(CMD_SUCC, 8'd0, 32'd0);
        push_cmd(CMD_SUCC, 8'd0, WORD_MAX);
        push_cmd(CMD_SUCC, 8'd0, 32'd12345);
        push_cmd(CMD_NOP, 8'd0, 32'd0);
        push_cmd(CMD_DELETE, 8'd255, 32'd0);
        push_cmd(CMD_DELETE, 8'd4, 32'd0);
        push_cmd(CMD_DELETE, 8'd1, 32'd0);
        push_cmd(CMD_CLEAR, 8'd0, 32'd0);

        // squared locate, including a wrapping square
        write_mode(1'b1);
        push_cmd(CMD_INSERT, 8'd1, 32'd9);
        push_cmd(CMD_INSERT, 8'd2, 32'd0);
        push_cmd(CMD_LOCATE, 8'd0, 32'd3);
        push_cmd(CMD_LOCATE, 8'd0, 32'hffff_fffd);
        push_cmd(CMD_LOCATE, 8'd0, WORD_MIN);
        push_cmd(CMD_PRED, 8'd0, 32'd0);
        push_cmd(CMD_CLEAR, 8'd0, 32'd0);

        write_mode(1'b0);
        run_random(320, 65, 8, 0);
        write_mode(1'b1);
        quiet_run = 1'b1;
        run_random(300, 30, 30, 1);
        write_mode(1'b0);
        quiet_run = 1'b0;
        run_random(200, 10, 60, 0);
        write_mode(1'b1);
        run_random(380, 55, 15, 1);

        wait_drained();
        repeat (CAPACITY + 8) @(posedge i_clk);

        $display("ran %0d commands over both match modes, %0d replies checked, peak length %0d of %0d",
                 cmds_taken, replies_checked, peak_length, CAPACITY);
        $display("reply codes seen: %0d ok, %0d bad position, %0d full, %0d not found",
                 status_tally[ST_OK], status_tally[ST_BAD_POS], status_tally[ST_FULL],
                 status_tally[ST_NONE]);
        if (error_count == 0 && predicted_replies.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== sequential_list_engine_core.f =====
rtl/core/sle_pkg.sv
rtl/core/sle_ctrl.sv
rtl/core/sle_dpath.sv
rtl/core/sequential_list_engine_core.sv
dv/sequential_list_engine_core_test.sv
